// ----- hdl/pps_disciplined_timestamp_core_defines.svh -----
// Assertion macros used by the checker file.
`ifndef PPS_DISCIPLINED_TIMESTAMP_CORE_DEFINES_SVH
`define PPS_DISCIPLINED_TIMESTAMP_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PDT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PDT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/pdt_pkg.sv -----
`default_nettype none

package pdt_pkg;

  localparam logic [31:0] NS_PER_SEC  = 32'd1000000000;
  localparam logic [31:0] SCALE_RESET = 32'd233016687;
  localparam logic [7:0]  SYNC_ONE    = 8'h16;
  localparam logic [7:0]  SYNC_TWO    = 8'h03;
  localparam logic [2:0]  LOAD_BYTES  = 3'd4;

  typedef enum logic [1:0] {
    OP_BYTE   = 2'd0,
    OP_PPS    = 2'd1,
    OP_TICK   = 2'd2,
    OP_PACKET = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    SYNC_WAIT    = 2'd0,
    SYNC_GOT_ONE = 2'd1,
    SYNC_LOADING = 2'd2,
    SYNC_TIME_OK = 2'd3
  } sync_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  rx_byte;
    logic        packet_ok;
    logic [31:0] packet_number;
    logic [31:0] sender_seconds;
    logic [31:0] sender_nanos;
  } in_item_t;

  typedef struct packed {
    logic [31:0] now_seconds;
    logic [31:0] now_nanos;
    logic [31:0] delay_ns;
    logic        delay_valid;
    logic [31:0] echo_number;
    logic        time_set;
  } out_item_t;

endpackage

`default_nettype wire

// ----- hdl/pps_disciplined_timestamp_core.sv -----
// PPS-disciplined time-of-day counter with one-way packet delay.
//
// Input channel (in_valid_i/in_ready_o/in_item_i): one beat per event: a serial
// byte for the sync parser, a PPS edge, a clock tick or a received packet.
// Output channel (out_valid_o/out_ready_i/out_item_o): exactly one result beat
// per input beat, in order, showing the time after that event and, for a good
// packet, the wrapped one-way delay in ns.
// Config channel (cfg_valid_i/cfg_ready_o/cfg_data_i): nanoseconds per cycle,
// Q8.24; always ready, write only while the block is idle.
//
// Throughput: one beat per cycle while the receiver takes results. An input beat's
// result passes the three register stages in order: state update, the two
// multipliers (cycles x scale, seconds difference x 1e9), then saturate and sum.
// When the receiver stalls, the output register holds its beat and the stages
// behind it fill; in_ready_o drops only when all three stages hold beats.
// Reset clears the time, the parser and all stage valids and loads the default
// scale; the block accepts beats in the first cycle after reset.
`default_nettype none

module pps_disciplined_timestamp_core
  import pdt_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o,
  input  wire logic      cfg_valid_i,
  output logic           cfg_ready_o,
  input  wire logic [31:0] cfg_data_i
);

  typedef struct packed {
    logic [31:0] seconds;
    logic [31:0] cycles;
    logic        good_pkt;
    logic [31:0] packet_number;
    logic [31:0] sender_seconds;
    logic [31:0] sender_nanos;
    logic        time_set;
  } stage_a_t;

  typedef struct packed {
    logic [31:0] seconds;
    logic [63:0] prod;
    logic [31:0] ds_ns;
    logic        good_pkt;
    logic [31:0] packet_number;
    logic [31:0] sender_nanos;
    logic        time_set;
  } stage_b_t;

  logic [31:0] scale_q;
  logic [31:0] seconds_q, seconds_d;
  logic [31:0] cycles_q, cycles_d;
  sync_e       sync_q, sync_d;
  logic [2:0]  idx_q, idx_d;
  logic [31:0] word_q, word_d;

  logic      a_valid_q, b_valid_q, o_valid_q;
  stage_a_t  a_q, a_d;
  stage_b_t  b_q, b_d;
  out_item_t o_q, o_d;

  logic in_fire, o_ready, b_ready;
  logic [2:0]  idx_inc;
  logic [31:0] word_ins;
  logic [31:0] nanos;

  // Stage ready chain: a stage can load when empty or when it moves on.
  assign o_ready    = !o_valid_q || out_ready_i;
  assign b_ready    = !b_valid_q || o_ready;
  assign in_ready_o = !a_valid_q || b_ready;
  assign in_fire    = in_valid_i && in_ready_o;

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = o_valid_q;
  assign out_item_o  = o_q;

  // Time state and sync parser update on each accepted beat.
  always_comb begin
    seconds_d = seconds_q;
    cycles_d  = cycles_q;
    sync_d    = sync_q;
    idx_d     = idx_q;
    word_d    = word_q;
    idx_inc   = idx_q + 3'd1;
    word_ins  = word_q;
    case (idx_q[1:0])
      2'd0:    word_ins[7:0]   = in_item_i.rx_byte;
      2'd1:    word_ins[15:8]  = in_item_i.rx_byte;
      2'd2:    word_ins[23:16] = in_item_i.rx_byte;
      default: word_ins[31:24] = in_item_i.rx_byte;
    endcase
    case (op_e'(in_item_i.opcode))
      OP_BYTE: begin
        case (sync_q)
          SYNC_WAIT: begin
            if (in_item_i.rx_byte == SYNC_ONE) sync_d = SYNC_GOT_ONE;
          end
          SYNC_GOT_ONE: begin
            if (in_item_i.rx_byte == SYNC_TWO) begin
              sync_d = SYNC_LOADING;
              idx_d  = 3'd0;
            end else begin
              sync_d = SYNC_WAIT;
            end
          end
          SYNC_LOADING: begin
            word_d = word_ins;
            idx_d  = idx_inc;
            if (idx_inc == LOAD_BYTES) begin
              seconds_d = word_ins;
              sync_d    = SYNC_TIME_OK;
            end
          end
          default: begin
            if (in_item_i.rx_byte == SYNC_ONE) sync_d = SYNC_GOT_ONE;
          end
        endcase
      end
      OP_PPS: begin
        seconds_d = seconds_q + 32'd1;
        cycles_d  = '0;
      end
      OP_TICK: begin
        cycles_d = cycles_q + 32'd1;
      end
      default: ;
    endcase

    a_d.seconds        = seconds_d;
    a_d.cycles         = cycles_d;
    a_d.good_pkt       = (op_e'(in_item_i.opcode) == OP_PACKET) && in_item_i.packet_ok;
    a_d.packet_number  = in_item_i.packet_number;
    a_d.sender_seconds = in_item_i.sender_seconds;
    a_d.sender_nanos   = in_item_i.sender_nanos;
    a_d.time_set       = (sync_d == SYNC_TIME_OK);
  end

  // Multiplier stage.
  always_comb begin
    b_d.seconds       = a_q.seconds;
    b_d.prod          = {32'd0, a_q.cycles} * {32'd0, scale_q};
    b_d.ds_ns         = (a_q.seconds - a_q.sender_seconds) * NS_PER_SEC;
    b_d.good_pkt      = a_q.good_pkt;
    b_d.packet_number = a_q.packet_number;
    b_d.sender_nanos  = a_q.sender_nanos;
    b_d.time_set      = a_q.time_set;
  end

  // Saturate the Q24 product and form the delay.
  always_comb begin
    nanos = (b_q.prod[63:56] != 8'd0) ? 32'hFFFF_FFFF : b_q.prod[55:24];
    o_d.now_seconds = b_q.seconds;
    o_d.now_nanos   = nanos;
    o_d.delay_ns    = b_q.good_pkt ? (b_q.ds_ns + (nanos - b_q.sender_nanos)) : 32'd0;
    o_d.delay_valid = b_q.good_pkt;
    o_d.echo_number = b_q.good_pkt ? b_q.packet_number : 32'd0;
    o_d.time_set    = b_q.time_set;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q   <= SCALE_RESET;
      seconds_q <= '0;
      cycles_q  <= '0;
      sync_q    <= SYNC_WAIT;
      idx_q     <= '0;
      word_q    <= '0;
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) scale_q <= cfg_data_i;
      if (in_fire) begin
        seconds_q <= seconds_d;
        cycles_q  <= cycles_d;
        sync_q    <= sync_d;
        idx_q     <= idx_d;
        word_q    <= word_d;
      end
      if (in_ready_o) a_valid_q <= in_valid_i;
      if (b_ready)    b_valid_q <= a_valid_q;
      if (o_ready)    o_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire)              a_q <= a_d;
    if (b_ready && a_valid_q) b_q <= b_d;
    if (o_ready && b_valid_q) o_q <= o_d;
  end

endmodule

`default_nettype wire

// ----- hdl/pdt_checker.sv -----
`default_nettype none
`include "pps_disciplined_timestamp_core_defines.svh"

module pdt_checker
  import pdt_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_ready_o,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire out_item_t out_item_o
);

  // A stalled result beat holds.
  `PDT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_item_o), "result beat changed while stalled")

  // With the output side free, the input side cannot be blocked.
  `PDT_ASSERT_NOW(a_ready_free, clk_i, rst_ni, !out_valid_o || out_ready_i, in_ready_o, "input blocked while output free")

  // No delay or echo without a good packet.
  `PDT_ASSERT_NOW(a_delay_zero, clk_i, rst_ni, out_valid_o && !out_item_o.delay_valid, out_item_o.delay_ns == 32'd0 && out_item_o.echo_number == 32'd0, "delay fields set without a good packet")

endmodule

bind pps_disciplined_timestamp_core pdt_checker u_pdt_checker (.*);

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

import pdt_pkg::*;

// Tracks time-of-day state and holds the result beats still owed by the block.
class tod_tracker;
  logic [31:0] scale;
  logic [31:0] seconds;
  logic [31:0] cycles;
  sync_e       sync_st;
  logic [2:0]  byte_idx;
  logic [31:0] assembly;
  out_item_t   expected_beats[$];
  int          mismatches;

  function new();
    scale      = SCALE_RESET;
    seconds    = '0;
    cycles     = '0;
    sync_st    = SYNC_WAIT;
    byte_idx   = '0;
    assembly   = '0;
    mismatches = 0;
  endfunction

  // cycles x Q8.24 scale, fraction dropped, clamped to 32 bits
  function logic [31:0] nanos_now();
    logic [63:0] prod;
    prod = {32'd0, cycles} * {32'd0, scale};
    if (prod[63:56] != 8'd0) return 32'hFFFF_FFFF;
    return prod[55:24];
  endfunction

  function void parse_rx(logic [7:0] rx);
    case (sync_st)
      SYNC_WAIT: begin
        if (rx == SYNC_ONE) sync_st = SYNC_GOT_ONE;
      end
      SYNC_GOT_ONE: begin
        if (rx == SYNC_TWO) begin
          sync_st  = SYNC_LOADING;
          byte_idx = '0;
        end else begin
          sync_st = SYNC_WAIT;
        end
      end
      SYNC_LOADING: begin
        assembly[byte_idx[1:0]*8 +: 8] = rx;
        byte_idx = byte_idx + 3'd1;
        if (byte_idx == LOAD_BYTES) begin
          seconds = assembly;
          sync_st = SYNC_TIME_OK;
        end
      end
      default: begin
        if (rx == SYNC_ONE) sync_st = SYNC_GOT_ONE;
      end
    endcase
  endfunction

  function void note_event(in_item_t it);
    out_item_t   r;
    logic [31:0] ds;
    logic [31:0] dn;
    r = '0;
    case (op_e'(it.opcode))
      OP_BYTE: parse_rx(it.rx_byte);
      OP_PPS: begin
        seconds = seconds + 32'd1;
        cycles  = '0;
      end
      OP_TICK: cycles = cycles + 32'd1;
      default: begin
        if (it.packet_ok) begin
          ds            = seconds - it.sender_seconds;
          dn            = nanos_now() - it.sender_nanos;
          r.delay_ns    = ds * NS_PER_SEC + dn;
          r.delay_valid = 1'b1;
          r.echo_number = it.packet_number;
        end
      end
    endcase
    r.now_seconds = seconds;
    r.now_nanos   = nanos_now();
    r.time_set    = (sync_st == SYNC_TIME_OK);
    expected_beats.push_back(r);
  endfunction

  function void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  function void check_beat(out_item_t got);
    out_item_t want;
    if (expected_beats.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
      return;
    end
    want = expected_beats.pop_front();
    compare_field("now_seconds", want.now_seconds, got.now_seconds);
    compare_field("now_nanos", want.now_nanos, got.now_nanos);
    compare_field("delay_ns", want.delay_ns, got.delay_ns);
    compare_field("delay_valid", 32'(want.delay_valid), 32'(got.delay_valid));
    compare_field("echo_number", want.echo_number, got.echo_number);
    compare_field("time_set", 32'(want.time_set), 32'(got.time_set));
  endfunction

  function int pending();
    return expected_beats.size();
  endfunction
endclass

module testbench;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  in_item_t    in_item   = '0;
  logic        out_ready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [31:0] cfg_data  = '0;

  logic        in_ready_o;
  logic        out_valid_o;
  out_item_t   out_item_o;
  logic        cfg_ready_o;

  int          send_gap_pct   = 0;
  int          recv_stall_pct = 0;
  int unsigned cycle_total    = 0;

  tod_tracker  tracker;

  pps_disciplined_timestamp_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_total <= cycle_total + 1;
    if (cycle_total >= CYCLE_LIMIT) begin
      $display("pps_disciplined_timestamp_core regression: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready_o) tracker.note_event(in_item);
      if (out_valid_o && out_ready) tracker.check_beat(out_item_o);
    end
  end

  always @(negedge clk_i) begin
    out_ready = ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function automatic in_item_t noise_item();
    in_item_t it;
    it.opcode         = 2'($urandom);
    it.rx_byte        = 8'($urandom);
    it.packet_ok      = 1'($urandom);
    it.packet_number  = $urandom;
    it.sender_seconds = $urandom;
    it.sender_nanos   = $urandom;
    return it;
  endfunction

  // random content in the fields the opcode does not use
  function automatic in_item_t with_op(op_e op);
    in_item_t it;
    it        = noise_item();
    it.opcode = op;
    return it;
  endfunction

  function automatic in_item_t mk(op_e op, logic [7:0] rx, logic ok, logic [31:0] num,
                                  logic [31:0] ss, logic [31:0] sn);
    in_item_t it;
    it.opcode         = op;
    it.rx_byte        = rx;
    it.packet_ok      = ok;
    it.packet_number  = num;
    it.sender_seconds = ss;
    it.sender_nanos   = sn;
    return it;
  endfunction

  // entered and left at a falling edge; valid stays high across back-to-back beats
  task automatic send_item(input in_item_t it);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_item  = it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_scale(input logic [31:0] value);
    in_valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid = 1'b1;
    cfg_data  = value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    tracker.scale = value;
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  task automatic random_phase(input int n);
    int       sent;
    int       pick;
    int       k;
    in_item_t it;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        k = $urandom_range(1, 24);
        repeat (k) send_item(with_op(OP_TICK));
        sent += k;
      end else if (pick < 38) begin
        send_item(with_op(OP_PPS));
        sent++;
      end else if (pick < 55) begin
        // full sync frame, random seconds
        it = with_op(OP_BYTE);
        it.rx_byte = SYNC_ONE;
        send_item(it);
        it = with_op(OP_BYTE);
        it.rx_byte = SYNC_TWO;
        send_item(it);
        repeat (4) send_item(with_op(OP_BYTE));
        sent += 6;
      end else if (pick < 63) begin
        // first sync byte followed by anything
        it = with_op(OP_BYTE);
        it.rx_byte = SYNC_ONE;
        send_item(it);
        send_item(with_op(OP_BYTE));
        sent += 2;
      end else if (pick < 92) begin
        it = with_op(OP_PACKET);
        it.packet_ok = ($urandom_range(0, 7) != 0);
        if ($urandom_range(0, 1) != 0) begin
          // sender close to local time, so the delay stays small
          it.sender_seconds = tracker.seconds - 32'($urandom_range(0, 2));
          it.sender_nanos   = tracker.nanos_now() - 32'($urandom_range(0, 5000));
        end
        send_item(it);
        sent++;
      end else begin
        send_item(noise_item());
        sent++;
      end
    end
  endtask

  initial begin
    int          p;
    logic [31:0] phase_scale [6];
    int          gap_tbl [4];
    int          stall_tbl [4];

    tracker     = new();
    phase_scale = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0100_0000, $urandom,
                    32'h0000_0001, SCALE_RESET};
    gap_tbl     = '{0, 85, 0, 25};
    stall_tbl   = '{0, 0, 85, 25};

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_item(mk(OP_TICK, 8'h00, 1'b0, '0, '0, '0));
    send_item(mk(OP_PACKET, 8'hFF, 1'b1, '0, '0, '0));
    send_item(mk(OP_PACKET, 8'hFF, 1'b0, '1, '1, '1));   // bad packet
    send_item(mk(OP_BYTE, SYNC_ONE, 1'b0, '0, '0, '0));
    send_item(mk(OP_BYTE, 8'h55, 1'b0, '0, '0, '0));     // wrong second sync byte
    send_item(mk(OP_BYTE, SYNC_ONE, 1'b0, '0, '0, '0));
    send_item(mk(OP_BYTE, SYNC_TWO, 1'b0, '0, '0, '0));
    send_item(mk(OP_BYTE, 8'h78, 1'b0, '0, '0, '0));
    send_item(mk(OP_BYTE, 8'h56, 1'b0, '0, '0, '0));
    send_item(mk(OP_BYTE, 8'h34, 1'b0, '0, '0, '0));
    send_item(mk(OP_BYTE, 8'h12, 1'b0, '0, '0, '0));
    send_item(mk(OP_TICK, 8'h00, 1'b1, '1, '1, '1));
    send_item(mk(OP_PPS, 8'hFF, 1'b1, '1, '1, '1));
    send_item(mk(OP_TICK, 8'h00, 1'b0, '0, '0, '0));
    send_item(mk(OP_PACKET, 8'h00, 1'b1, '1, '1, '1));
    send_item(mk(OP_BYTE, SYNC_ONE, 1'b0, '0, '0, '0));  // resync while time is loaded
    send_item(mk(OP_BYTE, 8'hFF, 1'b0, '0, '0, '0));     // not the second sync byte; parser returns to waiting
    send_item(mk(OP_BYTE, SYNC_ONE, 1'b0, '0, '0, '0));
    send_item(mk(OP_BYTE, SYNC_TWO, 1'b0, '0, '0, '0));
    repeat (4) send_item(mk(OP_BYTE, 8'hFF, 1'b0, '0, '0, '0));
    send_item(mk(OP_PPS, 8'h00, 1'b0, '0, '0, '0));      // seconds wrap to zero
    send_item(mk(OP_PACKET, 8'h00, 1'b1, '0, 32'h1, '0));

    for (p = 0; p < 6; p++) begin
      write_scale(phase_scale[p]);
      send_gap_pct   = gap_tbl[p % 4];
      recv_stall_pct = stall_tbl[p % 4];
      random_phase(160);
    end

    in_valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("pps_disciplined_timestamp_core regression: pass");
    end else begin
      $display("pps_disciplined_timestamp_core regression: fail");
    end
    $finish;
  end

endmodule
